@@ hw/rtl/srqm_pkg.sv @@
// Shared types and codes for the slot ring queue manager.
package srqm_pkg;

   localparam int IDX_W   = 10;
   localparam int LEN_W   = 16;
   localparam int STAMP_W = 32;
   localparam int BB_W    = 17;
   localparam int CNT_W   = 11;
   localparam int ADDR_W  = 26;
   localparam int KIND_W  = 3;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT  = 1'b1;

   localparam logic [BB_W-1:0]  BLOCK_BYTES_RESET = 17'd8192;
   localparam logic [CNT_W-1:0] SLOT_COUNT_RESET  = 11'd1024;

   typedef enum logic [KIND_W-1:0] {
      OP_PUSH = 3'd0,
      OP_POP  = 3'd1,
      OP_PULL = 3'd2,
      OP_GET  = 3'd3,
      OP_SET  = 3'd4,
      OP_BAD  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_BAD_LEN = 2'd2,
      ST_BAD_IDX = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      BK_CLEAR = 2'd0,
      BK_READ  = 2'd1,
      BK_EXEC  = 2'd2
   } back_state_type;

   typedef struct packed {
      op_type               op;
      logic                 len_bad;
      logic                 idx_bad;
      logic [IDX_W-1:0]     index;
      logic [LEN_W-1:0]     length;
      logic [STAMP_W-1:0]   now;
   } cmd_type;

   typedef struct packed {
      status_type           status;
      logic [IDX_W-1:0]     slot;
      logic [LEN_W-1:0]     stored_length;
      logic [STAMP_W-1:0]   stamp;
      logic [ADDR_W-1:0]    payload_address;
   } rsp_type;

endpackage

@@ hw/rtl/slot_ring_queue_manager_core.sv @@
// Top level of the slot ring queue manager: control registers and the front/back pipeline.
//
// A ring of SLOTS message slot headers (length and timestamp; length zero
// means empty) with push, pop, pull, get and set operations. Each request
// transfer yields exactly one response transfer, in request order, carrying
// a status, the slot touched, its length, its timestamp and the byte address
// of its payload (slot * block_bytes + HEADER_BYTES, modulo 2^26); the payload
// itself lives in an external memory. In the back end, each operation first
// reads the slot header from the single-port header store and registers the
// address product; then, once the response register is free, it writes the
// header back, moves the ring positions and loads the response register. The
// back end starts the next operation only once the last is through. A 2-entry
// command queue lets requests arrive while the back end or the response side is
// stalled, and the response register lets the next operation start while a
// result waits. After reset the header store is cleared one slot per cycle,
// over all SLOTS slots; req_tready stays low during that pass, CSR writes are
// taken as usual. Write CSRs only while no operation is outstanding.
module slot_ring_queue_manager_core import srqm_pkg::*; #(
   parameter int SLOTS        = 1024,
   parameter int HEADER_BYTES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,  // index[9:0], length[25:10], now[57:26], zero pad
   input  logic [KIND_W-1:0]     req_tuser,  // kind[2:0]
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [87:0]           rsp_tdata,  // slot[9:0], stored_length[25:10],
                                             // stamp[57:26], payload_address[83:58], zero pad
   output logic [1:0]            rsp_tuser,  // status[1:0]
   // CSR write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [BB_W-1:0]       csr_wdata
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CMP_W  = (SLOT_W + 1 > CNT_W) ? SLOT_W + 1 : CNT_W;
   localparam int FIFO_DEPTH = 2;

   logic [BB_W-1:0]   block_bytes_ff, block_bytes_in;
   logic [CNT_W-1:0]  slot_count_ff, slot_count_in;
   logic [SLOT_W:0]   ring_size;

   logic              clearing;
   logic              fifo_push, fifo_pop, fifo_full, fifo_empty;
   cmd_type           front_cmd, fifo_head;
   rsp_type           rsp;

   // CSR writes: latch the addressed register, drop bits above its width.
   always_comb begin
      block_bytes_in = block_bytes_ff;
      slot_count_in  = slot_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BLOCK_BYTES: block_bytes_in = csr_wdata;
            CSR_SLOT_COUNT:  slot_count_in  = csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff <= BLOCK_BYTES_RESET;
         slot_count_ff  <= SLOT_COUNT_RESET;
      end else begin
         block_bytes_ff <= block_bytes_in;
         slot_count_ff  <= slot_count_in;
      end
   end

   // Ring size in effect: a count of zero acts as one, counts above SLOTS clamp.
   always_comb begin
      if (slot_count_ff == '0) begin
         ring_size = (SLOT_W + 1)'(1);
      end else if (CMP_W'(slot_count_ff) > CMP_W'(SLOTS)) begin
         ring_size = (SLOT_W + 1)'(SLOTS);
      end else begin
         ring_size = (SLOT_W + 1)'(slot_count_ff);
      end
   end

   srqm_front #(
      .SLOTS        (SLOTS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .block_bytes (block_bytes_ff),
      .ring_size   (ring_size),
      .clearing    (clearing),
      .fifo_full   (fifo_full),
      .fifo_push   (fifo_push),
      .cmd         (front_cmd)
   );

   srqm_cmd_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (front_cmd),
      .pop       (fifo_pop),
      .head      (fifo_head),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   srqm_back #(
      .SLOTS        (SLOTS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .block_bytes (block_bytes_ff),
      .ring_size   (ring_size),
      .fifo_empty  (fifo_empty),
      .fifo_head   (fifo_head),
      .fifo_pop    (fifo_pop),
      .clearing    (clearing),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp         (rsp)
   );

   // Pack the response transfer.
   assign rsp_tuser = rsp.status;
   assign rsp_tdata = {4'b0, rsp.payload_address, rsp.stamp, rsp.stored_length, rsp.slot};

endmodule

@@ hw/rtl/srqm_front.sv @@
// Front end: accept request transfers, decode the kind and check length and index.
module srqm_front import srqm_pkg::*; #(
   parameter int SLOTS        = 1024,
   parameter int HEADER_BYTES = 16
) (
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [63:0]                 req_tdata,
   input  logic [KIND_W-1:0]           req_tuser,
   input  logic [BB_W-1:0]             block_bytes,
   input  logic [$clog2(SLOTS):0]      ring_size,
   input  logic                        clearing,
   input  logic                        fifo_full,
   output logic                        fifo_push,
   output cmd_type                     cmd
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CMP_W  = (SLOT_W + 1 > IDX_W) ? SLOT_W + 1 : IDX_W;

   logic [IDX_W-1:0]   index;
   logic [LEN_W-1:0]   length;
   logic [STAMP_W-1:0] now;
   logic [BB_W-1:0]    cap;
   op_type             op;

   assign index  = req_tdata[IDX_W-1:0];
   assign length = req_tdata[IDX_W+LEN_W-1:IDX_W];
   assign now    = req_tdata[IDX_W+LEN_W+STAMP_W-1:IDX_W+LEN_W];

   // Hold off while the header store is being cleared or the queue is full.
   assign req_tready = !clearing && !fifo_full;
   assign fifo_push  = req_tvalid && req_tready;

   always_comb begin
      unique case (req_tuser)
         OP_PUSH: op = OP_PUSH;
         OP_POP:  op = OP_POP;
         OP_PULL: op = OP_PULL;
         OP_GET:  op = OP_GET;
         OP_SET:  op = OP_SET;
         default: op = OP_BAD;
      endcase
   end

   // Usable payload bytes per slot; zero when the block is no larger than the header.
   assign cap = (block_bytes > BB_W'(HEADER_BYTES)) ? block_bytes - BB_W'(HEADER_BYTES)
                                                    : '0;

   always_comb begin
      cmd.op      = op;
      cmd.len_bad = (length == '0) || ({1'b0, length} > cap);
      cmd.idx_bad = CMP_W'(index) >= CMP_W'(ring_size);
      cmd.index   = index;
      cmd.length  = length;
      cmd.now     = now;
   end

endmodule

@@ hw/rtl/srqm_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
module srqm_cmd_fifo import srqm_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W_Q = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W_Q-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W_Q'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/srqm_back.sv @@
// Back end: slot header store, ring positions and result register.
module srqm_back import srqm_pkg::*; #(
   parameter int SLOTS        = 1024,
   parameter int HEADER_BYTES = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [BB_W-1:0]         block_bytes,
   input  logic [$clog2(SLOTS):0]  ring_size,
   input  logic                    fifo_empty,
   input  cmd_type                 fifo_head,
   output logic                    fifo_pop,
   output logic                    clearing,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output rsp_type                 rsp
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int MEM_W  = STAMP_W + LEN_W;
   localparam int PROD_W = SLOT_W + BB_W;

   logic [MEM_W-1:0]    mem [SLOTS];
   logic [MEM_W-1:0]    rd_ff;
   logic                rd_en;

   back_state_type      state_ff, state_in;
   logic [SLOT_W-1:0]   clr_ff, clr_in;
   logic [SLOT_W-1:0]   push_ff, push_in;
   logic [SLOT_W-1:0]   pull_ff, pull_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   cmd_type             cmd_ff, cmd_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [ADDR_W-1:0]   prod_ff, prod_in;

   logic [SLOT_W-1:0]   slot_sel;
   logic [PROD_W-1:0]   prod_full;
   logic                out_free;
   logic                mem_we;
   logic [SLOT_W-1:0]   mem_wa;
   logic [MEM_W-1:0]    mem_wd;

   logic [LEN_W-1:0]    held_len;
   logic [STAMP_W-1:0]  held_stamp;
   logic [ADDR_W-1:0]   addr;
   logic [SLOT_W:0]     slot_inc;
   logic [SLOT_W-1:0]   slot_adv;
   rsp_type             res;
   logic                res_we;
   logic [MEM_W-1:0]    res_wd;
   logic [SLOT_W-1:0]   res_push;
   logic [SLOT_W-1:0]   res_pull;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign clearing   = (state_ff == BK_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp        = rsp_ff;

   // Slot chosen by the command at the head of the queue.
   always_comb begin
      unique case (fifo_head.op)
         OP_PUSH: slot_sel = push_ff;
         OP_POP:  slot_sel = (push_ff == '0) ? SLOT_W'(ring_size - 1'b1) : push_ff - 1'b1;
         OP_PULL: slot_sel = pull_ff;
         OP_GET,
         OP_SET:  slot_sel = SLOT_W'(fifo_head.index);
         default: slot_sel = '0;
      endcase
   end

   assign prod_full = PROD_W'(slot_sel) * PROD_W'(block_bytes);

   // Execute one command against the header read in the BK_READ state.
   assign held_len   = rd_ff[LEN_W-1:0];
   assign held_stamp = rd_ff[MEM_W-1:LEN_W];
   assign addr       = prod_ff + ADDR_W'(HEADER_BYTES);
   assign slot_inc   = {1'b0, slot_ff} + 1'b1;
   assign slot_adv   = (slot_inc >= ring_size) ? '0 : SLOT_W'(slot_inc);

   always_comb begin
      res.status          = ST_OK;
      res.slot            = IDX_W'(slot_ff);
      res.stored_length   = '0;
      res.stamp           = '0;
      res.payload_address = '0;
      res_we              = 1'b0;
      res_wd              = '0;
      res_push            = push_ff;
      res_pull            = pull_ff;
      unique case (cmd_ff.op)
         OP_PUSH: begin
            res.stored_length   = cmd_ff.length;
            res.payload_address = addr;
            if (cmd_ff.len_bad) begin
               res.status = ST_BAD_LEN;
               res.stamp  = held_stamp;
            end else begin
               res.stamp = cmd_ff.now;
               res_we    = 1'b1;
               res_wd    = {cmd_ff.now, cmd_ff.length};
               res_push  = slot_adv;
            end
         end
         OP_POP: begin
            // Step back even when the slot turns out empty.
            res_push            = slot_ff;
            res.stamp           = held_stamp;
            res.payload_address = addr;
            if (held_len == '0) begin
               res.status = ST_EMPTY;
            end else begin
               res.stored_length = held_len;
               res_we            = 1'b1;
               res_wd            = {held_stamp, {LEN_W{1'b0}}};
            end
         end
         OP_PULL: begin
            res.stamp           = held_stamp;
            res.payload_address = addr;
            if (held_len == '0) begin
               res.status = ST_EMPTY;
            end else begin
               res.stored_length = held_len;
               res_we            = 1'b1;
               res_wd            = {held_stamp, {LEN_W{1'b0}}};
               res_pull          = slot_adv;
            end
         end
         OP_GET: begin
            res.slot = cmd_ff.index;
            if (cmd_ff.idx_bad) begin
               res.status = ST_BAD_IDX;
            end else begin
               res.stored_length   = held_len;
               res.stamp           = held_stamp;
               res.payload_address = addr;
            end
         end
         OP_SET: begin
            res.slot          = cmd_ff.index;
            res.stored_length = cmd_ff.length;
            if (cmd_ff.len_bad) begin
               // Length check wins over the index check.
               res.status = ST_BAD_LEN;
               if (!cmd_ff.idx_bad) begin
                  res.stamp           = held_stamp;
                  res.payload_address = addr;
               end
            end else if (cmd_ff.idx_bad) begin
               res.status = ST_BAD_IDX;
            end else begin
               res.stamp           = cmd_ff.now;
               res.payload_address = addr;
               res_we              = 1'b1;
               res_wd              = {cmd_ff.now, cmd_ff.length};
            end
         end
         default: begin
            res.status = ST_BAD_IDX;
            res.slot   = '0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: if (clr_ff == SLOT_W'(SLOTS - 1)) state_in = BK_READ;
         BK_READ:  if (!fifo_empty) state_in = BK_EXEC;
         BK_EXEC:  if (out_free) state_in = BK_READ;
         default:  state_in = BK_CLEAR;
      endcase
   end

   // State outputs.
   always_comb begin
      fifo_pop     = 1'b0;
      rd_en        = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = slot_ff;
      mem_wd       = res_wd;
      clr_in       = clr_ff;
      push_in      = push_ff;
      pull_in      = pull_ff;
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      prod_in      = prod_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         BK_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + 1'b1;
         end
         BK_READ: begin
            if (!fifo_empty) begin
               fifo_pop = 1'b1;
               rd_en    = 1'b1;
               cmd_in   = fifo_head;
               slot_in  = slot_sel;
               prod_in  = ADDR_W'(prod_full);
            end
         end
         BK_EXEC: begin
            if (out_free) begin
               mem_we       = res_we;
               push_in      = res_push;
               pull_in      = res_pull;
               rsp_in       = res;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         push_ff      <= '0;
         pull_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         push_ff      <= push_in;
         pull_ff      <= pull_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      slot_ff <= slot_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_ff <= mem[slot_sel];
      end
   end

endmodule
